// ===== sv/lant_pkg.sv =====
// ----------------------------------------------------------------------------
// lant_pkg
// Shared types and constants of the ant step unit: coordinate and heading
// types, heading codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lant_pkg;

    // grid coordinate inside the active area (at most 256 per axis)
    typedef logic [7:0] coord_t;
    // heading code
    typedef logic [1:0] heading_t;
    // active extent, 2..256
    typedef logic [8:0] extent_t;

    // heading codes
    localparam heading_t HEAD_PX = 2'd0;
    localparam heading_t HEAD_PY = 2'd1;
    localparam heading_t HEAD_NX = 2'd2;
    localparam heading_t HEAD_NY = 2'd3;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // reset values and limits
    localparam coord_t   ANT_START    = 8'd100;
    localparam heading_t HEAD_START   = HEAD_PX;
    localparam extent_t  EXTENT_RESET = 9'd200;
    localparam extent_t  EXTENT_MIN   = 9'd2;
    localparam int       EXTENT_CAP   = 256;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 9;

endpackage

`default_nettype wire

// ===== sv/langtons_ant_step_unit.sv =====
// ----------------------------------------------------------------------------
// langtons_ant_step_unit
// Langton's ant on a one-bit grid: each tick item reads the ant's cell,
// turns, flips the cell, moves with reflection at the active edges and
// returns one result item.
// ----------------------------------------------------------------------------
// channel   direction  fields
// s_axis    in         tick
// m_axis    out        cell_x, cell_y, painted_black, heading, next_x, next_y
// cfg       in         active_width (index 0), active_height (index 1)
//
// A tick item passes through the registered cell memory read and then the
// write-back with the ant update; the next item's address depends on that
// update, so a new item is taken only after the write-back of the last one.
// Items with tick zero are taken without a read and give no result.
// After reset the grid is cleared by a sweep over all GRID_COLS * GRID_ROWS
// cells (65536 by default); s_axis_tready stays low until it ends.
// A result waits in the output register; the next item is taken meanwhile,
// and its write-back stalls only while that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module langtons_ant_step_unit #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [lant_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [0] tick
    // output stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [7:0] cell_x, [15:8] cell_y, [16] painted_black, [18:17] heading,
    // [26:19] next_x, [34:27] next_y
    output logic [lant_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration write port
    input  wire                                 cfg_we,
    input  wire                                 cfg_index,
    input  wire  [lant_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LIM_W = (GRID_COLS < lant_pkg::EXTENT_CAP) ? GRID_COLS : lant_pkg::EXTENT_CAP;
    localparam int LIM_H = (GRID_ROWS < lant_pkg::EXTENT_CAP) ? GRID_ROWS : lant_pkg::EXTENT_CAP;
    localparam lant_pkg::extent_t EXT_MAX_W = 9'(LIM_W);
    localparam lant_pkg::extent_t EXT_MAX_H = 9'(LIM_H);

    // configuration
    lant_pkg::extent_t  width_reg;
    lant_pkg::extent_t  height_reg;
    lant_pkg::extent_t  ext_w;
    lant_pkg::extent_t  ext_h;

    // ant state
    lant_pkg::coord_t   ant_x_reg;
    lant_pkg::coord_t   ant_y_reg;
    lant_pkg::heading_t heading_reg;
    lant_pkg::coord_t   ant_x_next;
    lant_pkg::coord_t   ant_y_next;
    lant_pkg::heading_t heading_next;

    // read stage
    lant_pkg::coord_t   sat_x;
    lant_pkg::coord_t   sat_y;
    logic               in_accept;
    logic               rd_en;

    // write-back stage
    logic               b_valid_reg;
    logic               b_done;
    lant_pkg::coord_t   cur_x_reg;
    lant_pkg::coord_t   cur_y_reg;
    logic               cell_bit;
    logic               grid_ready;

    // output register
    logic               m_valid_reg;
    lant_pkg::coord_t   out_x_reg;
    lant_pkg::coord_t   out_y_reg;
    logic               out_black_reg;
    lant_pkg::heading_t out_heading_reg;
    lant_pkg::coord_t   out_nx_reg;
    lant_pkg::coord_t   out_ny_reg;

    // one axis move with reflection at the edges
    function automatic lant_pkg::coord_t axis_step(
        input lant_pkg::coord_t  pos,
        input logic              inc,
        input logic              dec,
        input lant_pkg::extent_t ext
    );
        lant_pkg::extent_t up;
        lant_pkg::coord_t  res;
        up  = {1'b0, pos} + 9'd1;
        res = pos;
        if (inc)
        begin
            res = (up < ext) ? pos + 8'd1 : pos - 8'd1;
        end
        else if (dec)
        begin
            res = (pos != 8'd0) ? pos - 8'd1 : pos + 8'd1;
        end
        return res;
    endfunction

    // clamp a register to the usable extent
    function automatic lant_pkg::extent_t clamp_extent(
        input lant_pkg::extent_t val,
        input lant_pkg::extent_t lim
    );
        lant_pkg::extent_t res;
        res = val;
        if (val < lant_pkg::EXTENT_MIN)
        begin
            res = lant_pkg::EXTENT_MIN;
        end
        else if (val > lim)
        begin
            res = lim;
        end
        return res;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lant_pkg::EXTENT_RESET;
            height_reg <= lant_pkg::EXTENT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lant_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                lant_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:              width_reg  <= width_reg;
            endcase
        end
    end

    assign ext_w = clamp_extent(width_reg, EXT_MAX_W);
    assign ext_h = clamp_extent(height_reg, EXT_MAX_H);

    // read stage: saturate the position into the active area and read
    assign sat_x = ({1'b0, ant_x_reg} >= ext_w) ? 8'(ext_w - 9'd1) : ant_x_reg;
    assign sat_y = ({1'b0, ant_y_reg} >= ext_h) ? 8'(ext_h - 9'd1) : ant_y_reg;

    assign s_axis_tready = grid_ready && !b_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign rd_en         = in_accept && s_axis_tdata[0];

    lant_grid #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_grid (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (rd_en),
        .rd_x   (sat_x),
        .rd_y   (sat_y),
        .rd_bit (cell_bit),
        .wr_en  (b_done),
        .wr_bit (!cell_bit),
        .ready  (grid_ready)
    );

    // write-back stage: turn, flip and move
    assign b_done = b_valid_reg && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        heading_next = cell_bit ? heading_reg - 2'd1 : heading_reg + 2'd1;
        ant_x_next   = axis_step(cur_x_reg, heading_next == lant_pkg::HEAD_PX,
                                 heading_next == lant_pkg::HEAD_NX, ext_w);
        ant_y_next   = axis_step(cur_y_reg, heading_next == lant_pkg::HEAD_PY,
                                 heading_next == lant_pkg::HEAD_NY, ext_h);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            ant_x_reg   <= lant_pkg::ANT_START;
            ant_y_reg   <= lant_pkg::ANT_START;
            heading_reg <= lant_pkg::HEAD_START;
        end
        else
        begin
            if (rd_en)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_done)
            begin
                m_valid_reg <= 1'b1;
                ant_x_reg   <= ant_x_next;
                ant_y_reg   <= ant_y_next;
                heading_reg <= heading_next;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_x_reg <= sat_x;
            cur_y_reg <= sat_y;
        end
        if (b_done)
        begin
            out_x_reg       <= cur_x_reg;
            out_y_reg       <= cur_y_reg;
            out_black_reg   <= !cell_bit;
            out_heading_reg <= heading_next;
            out_nx_reg      <= ant_x_next;
            out_ny_reg      <= ant_y_next;
        end
    end

    // output packing
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, out_ny_reg, out_nx_reg, out_heading_reg,
                            out_black_reg, out_y_reg, out_x_reg};

    // no item enters before the clear sweep ends
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> grid_ready)
        else $error("item accepted during grid clear");

    // a new result only comes from a finished write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(b_valid_reg))
        else $error("result without a pending item");

    // the turn follows the new color of the flipped cell
    assert property (@(posedge clk) disable iff (!rst_n)
        b_done |=> ((out_black_reg && heading_reg == 2'($past(heading_reg) + 2'd1)) ||
                    (!out_black_reg && heading_reg == 2'($past(heading_reg) - 2'd1))))
        else $error("heading turn does not match cell color");

    // the ant stays inside the active area after a move
    assert property (@(posedge clk) disable iff (!rst_n)
        b_done |=> ({1'b0, ant_x_reg} < $past(ext_w) && {1'b0, ant_y_reg} < $past(ext_h)))
        else $error("ant left the active area");

endmodule

`default_nettype wire

// ===== sv/lant_grid.sv =====
// ----------------------------------------------------------------------------
// lant_grid
// One-bit cell memory with a registered read port. The write port writes
// back to the address of the last read. After reset a sweep clears every
// cell to white, one cell per cycle, before ready goes high.
// ----------------------------------------------------------------------------
`default_nettype none

module lant_grid #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire              clk,
    input  wire              rst_n,
    // read request at a cell position
    input  wire              rd_en,
    input  lant_pkg::coord_t rd_x,
    input  lant_pkg::coord_t rd_y,
    output logic             rd_bit,
    // write back to the last read position
    input  wire              wr_en,
    input  wire              wr_bit,
    // clear sweep finished
    output logic             ready
);

    localparam int DEPTH  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic              mem_array [0:DEPTH-1];
    logic              rd_bit_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;

    // row-major cell address
    assign rd_addr = ADDR_W'(ADDR_W'(rd_y) * ADDR_W'(GRID_COLS)) + ADDR_W'(rd_x);

    // clear sweep control
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // write port: sweep or write-back
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 1'b0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = addr_reg;
            mem_wdata = wr_bit;
        end
    end

    // memory array and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_bit_reg <= mem_array[rd_addr];
            addr_reg   <= rd_addr;
        end
    end

    assign rd_bit = rd_bit_reg;
    assign ready  = !clearing_reg;

endmodule

`default_nettype wire
